@@ sv/linear_array_deque_core_defines.svh @@
// assertion macros for the deque core
`ifndef LINEAR_ARRAY_DEQUE_CORE_DEFINES_SVH
`define LINEAR_ARRAY_DEQUE_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define LAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lad_pkg.sv @@
package lad_pkg;

  localparam int unsigned DEF_CAPACITY = 8;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } lad_op_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } lad_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_OUT  = 1'b1
  } lad_state_t;

  typedef struct packed {
    logic exec;
  } lad_cmd_t;

endpackage

@@ sv/linear_array_deque_core.sv @@
// channel  | handshake            | payload
// ---------+----------------------+---------------------------
// in       | in_valid / in_ready  | operation, value
// out      | out_valid / out_ready| status, popped_value
//
// an operation is applied in the cycle of its transfer; the result is
// shown from the next cycle, so with out_ready high one item per cycle
// the popped value comes from the slot ram's registered read port
// a new item is taken in the same cycle that the pending result transfers
// a stalled result holds the block; reset leaves the deque empty, slots
// keep their contents and need no clearing
module linear_array_deque_core
  import lad_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value
);

  lad_cmd_t cmd;

  lad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  lad_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .value       (value),
    .status      (status),
    .popped_value(popped_value)
  );

endmodule

@@ sv/lad_ram.sv @@
module lad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lad_ctrl.sv @@
module lad_ctrl
  import lad_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lad_cmd_t cmd
);

  lad_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          state_next = in_valid ? ST_OUT : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.exec = in_valid && in_ready;
  end

endmodule

@@ sv/lad_dp.sv @@
`include "linear_array_deque_core_defines.svh"

module lad_dp
  import lad_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lad_cmd_t                 cmd,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] value,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [IDX_W-1:0] front_index, front_index_next;
  logic [IDX_W-1:0] rear_index, rear_index_next;
  logic             is_empty, is_empty_next;
  lad_status_t      res_status, res_status_next;
  logic             pop_ok, pop_ok_next;

  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;
  lad_op_t           op;

  assign op = lad_op_t'(operation);

  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    is_empty_next    = is_empty;
    res_status_next  = STATUS_DONE;
    pop_ok_next      = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = front_index;
    rd_en            = 1'b0;
    rd_addr          = front_index;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (is_empty) begin
          front_index_next = '0;
          rear_index_next  = '0;
          is_empty_next    = 1'b0;
          wr_en            = cmd.exec;
          wr_addr          = '0;
        end else if (op == OP_PUSH_FRONT) begin
          if (front_index == '0) begin
            res_status_next = STATUS_OVERFLOW;
          end else begin
            front_index_next = front_index - 1'b1;
            wr_en            = cmd.exec;
            wr_addr          = front_index - 1'b1;
          end
        end else begin
          if (rear_index == LAST_IDX) begin
            res_status_next = STATUS_OVERFLOW;
          end else begin
            rear_index_next = rear_index + 1'b1;
            wr_en           = cmd.exec;
            wr_addr         = rear_index + 1'b1;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (is_empty) begin
          res_status_next = STATUS_UNDERFLOW;
        end else begin
          pop_ok_next = 1'b1;
          rd_en       = cmd.exec;
          rd_addr     = (op == OP_POP_FRONT) ? front_index : rear_index;
          if (front_index == rear_index) begin
            is_empty_next    = 1'b1;
            front_index_next = '0;
            rear_index_next  = '0;
          end else if (op == OP_POP_FRONT) begin
            front_index_next = front_index + 1'b1;
          end else begin
            rear_index_next = rear_index - 1'b1;
          end
        end
      end
      default: begin
        res_status_next = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      is_empty    <= 1'b1;
    end else if (cmd.exec) begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      is_empty    <= is_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= res_status_next;
      pop_ok     <= pop_ok_next;
    end
  end

  lad_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign status       = res_status;
  assign popped_value = pop_ok ? rd_data : '0;

  `LAD_ASSERT_SAME(a_empty_at_base, is_empty, (front_index == '0) && (rear_index == '0), "empty deque with nonzero index")
  `LAD_ASSERT_SAME(a_order, !is_empty, front_index <= rear_index, "front index above rear index")
  `LAD_ASSERT_NEXT(a_push_fills, cmd.exec && !operation[1], !is_empty, "deque empty after a push")

endmodule
